// File: rtl/lsrc_pkg.sv
// Shared types, constants and step codes for the line segment rectangle clipper.
`default_nettype none
package lsrc_pkg;

    // Coordinate width and default number of fraction bits.
    localparam int CW       = 20;
    localparam int FRAC_DEF = 4;
    // Width of a difference of two coordinates.
    localparam int DW       = CW + 1;

    typedef logic signed [CW-1:0] t_coord;

    // Segment state carried down the pipeline.
    typedef struct packed {
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
        logic   rej;
    } t_seg;

    // Window edges.
    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_win;

    // Clip steps in the order they are applied.
    typedef enum logic [2:0] {
        STEP_LEFT  = 3'd0,
        STEP_RIGHT = 3'd1,
        STEP_TOP1  = 3'd2,
        STEP_TOP2  = 3'd3,
        STEP_BOT1  = 3'd4,
        STEP_BOT2  = 3'd5
    } t_step;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WIN_LEFT   = 2'd0,
        CFG_WIN_TOP    = 2'd1,
        CFG_WIN_RIGHT  = 2'd2,
        CFG_WIN_BOTTOM = 2'd3
    } t_cfg_idx;

    localparam int NUM_STEPS = 6;

endpackage
`default_nettype wire

// File: rtl/lsrc_front.sv
// Front stage: trivial rejection against the window and ordering of the ends by x.
`default_nettype none
module lsrc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire lsrc_pkg::t_coord i_ax,
    input  wire lsrc_pkg::t_coord i_ay,
    input  wire lsrc_pkg::t_coord i_bx,
    input  wire lsrc_pkg::t_coord i_by,
    input  wire lsrc_pkg::t_win  i_win,
    output logic                 o_valid,
    output lsrc_pkg::t_seg       o_seg
);
    import lsrc_pkg::*;

    logic r_valid;
    t_seg r_seg;
    t_seg n_seg;

    // Reject when both ends are outside the same edge, then order by x.
    always_comb begin
        n_seg.rej = ((i_ax < i_win.left)   && (i_bx < i_win.left))  ||
                    ((i_ax > i_win.right)  && (i_bx > i_win.right)) ||
                    ((i_ay < i_win.top)    && (i_by < i_win.top))   ||
                    ((i_ay > i_win.bottom) && (i_by > i_win.bottom));
        if (i_bx < i_ax) begin
            n_seg.x1 = i_bx;
            n_seg.y1 = i_by;
            n_seg.x2 = i_ax;
            n_seg.y2 = i_ay;
        end else begin
            n_seg.x1 = i_ax;
            n_seg.y1 = i_ay;
            n_seg.x2 = i_bx;
            n_seg.y2 = i_by;
        end
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg <= n_seg;
        end
    end

    assign o_valid = r_valid;
    assign o_seg   = r_seg;

endmodule
`default_nettype wire

// File: rtl/lsrc_clip_step.sv
// One clip step: edge test, pipelined slope division, multiply and saturating update.
`default_nettype none
module lsrc_clip_step #(
    parameter int              FRAC = lsrc_pkg::FRAC_DEF,
    parameter lsrc_pkg::t_step STEP = lsrc_pkg::STEP_LEFT
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire lsrc_pkg::t_win i_win,
    input  wire logic           i_valid,
    input  wire lsrc_pkg::t_seg i_seg,
    output logic                o_valid,
    output lsrc_pkg::t_seg      o_seg
);
    import lsrc_pkg::*;

    // Numerator magnitude after scaling, signed slope, product and sum widths.
    localparam int NW = DW + FRAC;
    localparam int QW = NW + 1;
    localparam int PW = QW + DW;
    localparam int SW = PW + 1;

    typedef struct packed {
        t_seg                 seg;
        logic                 cond;
        logic                 neg;
        logic                 dz;
        logic signed [DW-1:0] dlen;
        logic [DW-1:0]        dmag;
        logic [DW-1:0]        rem;
        logic [NW-1:0]        n;
        logic [NW-1:0]        q;
    } t_dv;

    t_seg                 n_seg;
    logic                 n_cond;
    logic signed [DW-1:0] n_dist;
    logic signed [DW-1:0] n_num;
    logic signed [DW-1:0] n_den;
    logic signed [DW-1:0] x1e, y1e, x2e, y2e;
    logic [DW-1:0]        num_mag;
    logic [DW-1:0]        den_mag;

    logic r_vld [NW+1];
    t_dv  r_dv  [NW+1];
    t_dv  n_dv0;

    // Sign-extended copies of the incoming coordinates.
    always_comb begin
        x1e = {i_seg.x1[CW-1], i_seg.x1};
        y1e = {i_seg.y1[CW-1], i_seg.y1};
        x2e = {i_seg.x2[CW-1], i_seg.x2};
        y2e = {i_seg.y2[CW-1], i_seg.y2};
    end

    // Edge test and the distance, numerator and denominator of this step.
    always_comb begin
        n_seg  = i_seg;
        n_cond = 1'b0;
        n_dist = '0;
        n_num  = y2e - y1e;
        n_den  = x2e - x1e;
        case (STEP)
            STEP_LEFT: begin
                n_cond = i_seg.x1 < i_win.left;
                n_dist = {i_win.left[CW-1], i_win.left} - x1e;
            end
            STEP_RIGHT: begin
                n_cond = i_seg.x2 > i_win.right;
                n_dist = {i_win.right[CW-1], i_win.right} - x2e;
            end
            STEP_TOP1: begin
                // After x clipping the segment may lie wholly above or below.
                if (((i_seg.y1 < i_win.top) && (i_seg.y2 < i_win.top)) ||
                    ((i_seg.y1 > i_win.bottom) && (i_seg.y2 > i_win.bottom))) begin
                    n_seg.rej = 1'b1;
                end
                n_cond = i_seg.y1 < i_win.top;
                n_dist = {i_win.top[CW-1], i_win.top} - y1e;
                n_num  = x2e - x1e;
                n_den  = y2e - y1e;
            end
            STEP_TOP2: begin
                n_cond = i_seg.y2 < i_win.top;
                n_dist = {i_win.top[CW-1], i_win.top} - y2e;
                n_num  = x2e - x1e;
                n_den  = y2e - y1e;
            end
            STEP_BOT1: begin
                n_cond = i_seg.y1 > i_win.bottom;
                n_dist = {i_win.bottom[CW-1], i_win.bottom} - y1e;
                n_num  = x2e - x1e;
                n_den  = y2e - y1e;
            end
            STEP_BOT2: begin
                n_cond = i_seg.y2 > i_win.bottom;
                n_dist = {i_win.bottom[CW-1], i_win.bottom} - y2e;
                n_num  = x2e - x1e;
                n_den  = y2e - y1e;
            end
            default: begin
                n_cond = 1'b0;
            end
        endcase
        n_cond = n_cond & ~n_seg.rej;
    end

    // Magnitudes for the unsigned divider; the sign is carried alongside.
    always_comb begin
        num_mag = n_num[DW-1] ? DW'(-n_num) : DW'(n_num);
        den_mag = n_den[DW-1] ? DW'(-n_den) : DW'(n_den);
        n_dv0.seg  = n_seg;
        n_dv0.cond = n_cond;
        n_dv0.neg  = n_num[DW-1] ^ n_den[DW-1];
        n_dv0.dz   = (n_den == '0);
        n_dv0.dlen = n_dist;
        n_dv0.dmag = den_mag;
        n_dv0.rem  = '0;
        n_dv0.n    = NW'(num_mag) << FRAC;
        n_dv0.q    = '0;
    end

    // Entry register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar g = 1; g <= NW; g++) begin : g_div
        t_dv         n_dv;
        logic [DW:0] trial;

        always_comb begin
            n_dv  = r_dv[g-1];
            trial = {r_dv[g-1].rem, r_dv[g-1].n[NW-1]} - {1'b0, r_dv[g-1].dmag};
            if (!trial[DW]) begin
                n_dv.rem = trial[DW-1:0];
                n_dv.q   = {r_dv[g-1].q[NW-2:0], 1'b1};
            end else begin
                n_dv.rem = {r_dv[g-1].rem[DW-2:0], r_dv[g-1].n[NW-1]};
                n_dv.q   = {r_dv[g-1].q[NW-2:0], 1'b0};
            end
            n_dv.n = r_dv[g-1].n << 1;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[g] <= n_dv;
            end
        end
    end

    // Multiply the signed slope by the distance.
    logic signed [QW-1:0] n_slope;
    logic signed [PW-1:0] n_prod;
    logic signed [PW-1:0] r_prod;
    t_seg                 r_mul_seg;
    logic                 r_mul_cond;
    logic                 r_mul_vld;

    always_comb begin
        if (r_dv[NW].dz) begin
            n_slope = '0;
        end else if (r_dv[NW].neg) begin
            n_slope = -$signed({1'b0, r_dv[NW].q});
        end else begin
            n_slope = $signed({1'b0, r_dv[NW].q});
        end
        n_prod = n_slope * r_dv[NW].dlen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
        end else if (i_en) begin
            r_mul_vld <= r_vld[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod     <= n_prod;
            r_mul_seg  <= r_dv[NW].seg;
            r_mul_cond <= r_dv[NW].cond;
        end
    end

    // Scale down toward zero, add to the moving coordinate and saturate.
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] delta;
    t_coord               base;
    logic [SW-1:0]        sum;
    t_coord               moved;
    t_seg                 n_out;
    logic                 r_out_vld;
    t_seg                 r_out_seg;

    always_comb begin
        rnd   = r_prod[PW-1] ? (r_prod + PW'((2 ** FRAC) - 1)) : r_prod;
        delta = rnd >>> FRAC;
        case (STEP)
            STEP_LEFT:  base = r_mul_seg.y1;
            STEP_RIGHT: base = r_mul_seg.y2;
            STEP_TOP1:  base = r_mul_seg.x1;
            STEP_TOP2:  base = r_mul_seg.x2;
            STEP_BOT1:  base = r_mul_seg.x1;
            STEP_BOT2:  base = r_mul_seg.x2;
            default:    base = r_mul_seg.x1;
        endcase
        sum = {{(SW-CW){base[CW-1]}}, base} + {delta[PW-1], delta};
        if (sum[SW-1:CW-1] == '0 || sum[SW-1:CW-1] == '1) begin
            moved = sum[CW-1:0];
        end else if (sum[SW-1]) begin
            moved = {1'b1, {(CW-1){1'b0}}};
        end else begin
            moved = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_comb begin
        n_out = r_mul_seg;
        if (r_mul_cond) begin
            case (STEP)
                STEP_LEFT: begin
                    n_out.y1 = moved;
                    n_out.x1 = i_win.left;
                end
                STEP_RIGHT: begin
                    n_out.y2 = moved;
                    n_out.x2 = i_win.right;
                end
                STEP_TOP1: begin
                    n_out.x1 = moved;
                    n_out.y1 = i_win.top;
                end
                STEP_TOP2: begin
                    n_out.x2 = moved;
                    n_out.y2 = i_win.top;
                end
                STEP_BOT1: begin
                    n_out.x1 = moved;
                    n_out.y1 = i_win.bottom;
                end
                STEP_BOT2: begin
                    n_out.x2 = moved;
                    n_out.y2 = i_win.bottom;
                end
                default: begin
                    n_out = r_mul_seg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_mul_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_seg <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_seg   = r_out_seg;

endmodule
`default_nettype wire

// File: rtl/line_segment_rect_clipper_unit.sv
// Top level of the line segment rectangle clipper: window registers and clip pipeline.
//
// Usage: a segment enters on the s_axis channel and its clipped result leaves on
// m_axis, one result per segment, in order. The window is set through the write
// port (i_cfg_we, i_cfg_idx, i_cfg_data) while no segment is in flight.
// Pipeline: one front stage for trivial rejection and x ordering, then six clip
// steps (left, right, top for each end, bottom for each end). Each step holds an
// entry register, a restoring divider of 21 + COORD_FRAC_BITS stages, one multiply
// stage and one update stage. Throughput is one segment per cycle while m_axis
// is not stalled. The divider chains set the latency; each divider stage resolves
// one quotient bit. Reset clears all valid bits and loads the default window; the
// pipeline is empty after reset. When the receiver stalls with a result waiting in
// the last stage, the whole pipeline holds and s_axis_tready falls; no transfer is
// lost or repeated. A rejected segment gives m_axis_tuser low and all coordinates
// zero.
`default_nettype none
module line_segment_rect_clipper_unit #(
    parameter int COORD_FRAC_BITS = lsrc_pkg::FRAC_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [19:0] i_cfg_data,
    // Segment input.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // ax, ay, bx, by from bit 0 up
    // Clipped result.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,  // left_x, left_y, right_x, right_y from bit 0 up
    output logic             m_axis_tuser   // visible
);
    import lsrc_pkg::*;

    t_win r_win;
    logic en;
    logic front_vld;
    t_seg front_seg;
    logic step_vld [NUM_STEPS+1];
    t_seg step_seg [NUM_STEPS+1];
    t_seg last_seg;

    // Window registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= '0;
            r_win.top    <= '0;
            r_win.right  <= {1'b0, {(CW-1){1'b1}}};
            r_win.bottom <= {1'b0, {(CW-1){1'b1}}};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIN_LEFT:   r_win.left   <= i_cfg_data;
                CFG_WIN_TOP:    r_win.top    <= i_cfg_data;
                CFG_WIN_RIGHT:  r_win.right  <= i_cfg_data;
                CFG_WIN_BOTTOM: r_win.bottom <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves whenever the last stage is empty or being taken.
    assign en            = ~step_vld[NUM_STEPS] | m_axis_tready;
    assign s_axis_tready = en;

    lsrc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_ax    (s_axis_tdata[19:0]),
        .i_ay    (s_axis_tdata[39:20]),
        .i_bx    (s_axis_tdata[59:40]),
        .i_by    (s_axis_tdata[79:60]),
        .i_win   (r_win),
        .o_valid (front_vld),
        .o_seg   (front_seg)
    );

    assign step_vld[0] = front_vld;
    assign step_seg[0] = front_seg;

    // Six clip steps in sequence.
    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        lsrc_clip_step #(
            .FRAC (COORD_FRAC_BITS),
            .STEP (t_step'(k))
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_win   (r_win),
            .i_valid (step_vld[k]),
            .i_seg   (step_seg[k]),
            .o_valid (step_vld[k+1]),
            .o_seg   (step_seg[k+1])
        );
    end

    // Result formatting: a rejected segment reads as all zeros.
    assign last_seg      = step_seg[NUM_STEPS];
    assign m_axis_tvalid = step_vld[NUM_STEPS];
    assign m_axis_tuser  = ~last_seg.rej;
    assign m_axis_tdata  = last_seg.rej ? '0 :
                           {last_seg.y2, last_seg.x2, last_seg.y1, last_seg.x1};

endmodule
`default_nettype wire
